@@ rtl/hdip_pkg.sv @@
// Shared types, codes and constants for the HID descriptor item parser.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package hdip_pkg;

   // Default sizes of the field store, the collection store and the global stack
   localparam int MAX_FIELDS_DEF      = 128;
   localparam int MAX_COLLECTIONS_DEF = 16;
   localparam int STACK_LEVELS_DEF    = 8;

   // Widths of counts carried between modules, sized for the largest store
   localparam int FIELD_W = 11;   // holds up to 2047 field entries
   localparam int COLL_W  = 9;    // holds up to 511 collections

   // Item type codes (prefix bits 3:2)
   localparam logic [1:0] KIND_MAIN   = 2'd0;
   localparam logic [1:0] KIND_GLOBAL = 2'd1;
   localparam logic [1:0] KIND_LOCAL  = 2'd2;

   // Size code that means four data bytes
   localparam logic [1:0] SIZE_FOUR = 2'd3;

   // Main item tags
   localparam logic [3:0] TAG_INPUT      = 4'h8;
   localparam logic [3:0] TAG_OUTPUT     = 4'h9;
   localparam logic [3:0] TAG_COLLECTION = 4'hA;
   localparam logic [3:0] TAG_FEATURE    = 4'hB;

   // Global item tags
   localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
   localparam logic [3:0] TAG_PUSH         = 4'hA;
   localparam logic [3:0] TAG_POP          = 4'hB;

   // Local item tags
   localparam logic [3:0] TAG_USAGE     = 4'h0;
   localparam logic [3:0] TAG_USAGE_MIN = 4'h1;
   localparam logic [3:0] TAG_USAGE_MAX = 4'h2;

   // Usage pages and usages of interest
   localparam logic [31:0] PAGE_DESKTOP   = 32'h01;
   localparam logic [31:0] PAGE_KEYBOARD  = 32'h07;
   localparam logic [31:0] PAGE_BUTTON    = 32'h09;
   localparam logic [31:0] PAGE_DIGITIZER = 32'h0D;
   localparam logic [31:0] USE_MOUSE      = 32'h02;
   localparam logic [31:0] USE_JOYSTICK   = 32'h04;
   localparam logic [31:0] USE_GAMEPAD    = 32'h05;
   localparam logic [31:0] USE_KEYBOARD   = 32'h06;
   localparam logic [31:0] AXIS_FIRST     = 32'h30;
   localparam logic [31:0] AXIS_LAST      = 32'h35;
   localparam int          AXIS_NUM       = 6;

   // Device type codes
   localparam logic [2:0] DEV_UNKNOWN     = 3'd0;
   localparam logic [2:0] DEV_KEYBOARD    = 3'd1;
   localparam logic [2:0] DEV_MOUSE       = 3'd2;
   localparam logic [2:0] DEV_JOYSTICK    = 3'd3;
   localparam logic [2:0] DEV_GAMEPAD     = 3'd4;
   localparam logic [2:0] DEV_TOUCHSCREEN = 3'd5;

   // Input word
   typedef struct packed {
      logic [7:0] descriptor_byte;
      logic       last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic        done_res;
      logic [2:0]  device_type;
      logic [31:0] key_count;
      logic [31:0] button_count;
      logic [7:0]  axis_count;
      logic [7:0]  fields_stored;
      logic [4:0]  collections_stored;
      logic        truncated;
   } rsp_type;

   // One complete item, ready to execute
   typedef struct packed {
      logic        valid;
      logic [3:0]  tag;
      logic [1:0]  kind;
      logic [1:0]  size;
      logic [31:0] value;
   } item_type;

   // Global and local values saved by push
   typedef struct packed {
      logic [31:0] page;
      logic [31:0] usage;
      logic [31:0] count;
      logic [31:0] umin;
      logic [31:0] umax;
   } globals_type;

   // Tracker stage output: running counts plus the field entries just added
   typedef struct packed {
      logic               done;
      logic               trunc;
      logic [2:0]         device_type;
      logic [FIELD_W-1:0] fields;
      logic [COLL_W-1:0]  colls;
      logic [FIELD_W-1:0] add_n;
      logic [31:0]        count;
      logic               page_kbd;
      logic               page_btn;
      logic               page_desk;
      logic [31:0]        umin;
   } track_type;

   // Tally stage output: increments ready to add to the totals
   typedef struct packed {
      logic               done;
      logic               trunc;
      logic [2:0]         device_type;
      logic [FIELD_W-1:0] fields;
      logic [COLL_W-1:0]  colls;
      logic [31:0]        key_add;
      logic [31:0]        btn_add;
      logic [2:0]         axis_inc;
   } tally_type;

endpackage

@@ rtl/hdip_item_gather.sv @@
// Item prefix decode and little-endian data gathering for the HID parser.
// Depends on hdip_pkg for the item and input word types.
`timescale 1ns / 1ps

module hdip_item_gather (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  hdip_pkg::req_type req_data,
   output hdip_pkg::item_type item,
   output logic              trunc
);

   logic [2:0]  pending_ff, pending_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] acc_new;
   logic [7:0]  b;

   assign b       = req_data.descriptor_byte;
   assign acc_new = acc_ff | (32'(b) << {pos_ff, 3'b000});

   // Decode a prefix or collect one data byte
   always_comb begin
      pending_in = pending_ff;
      prefix_in  = prefix_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      item       = '0;
      if (pending_ff == 3'd0) begin
         if (b[1:0] == 2'd0) begin
            item.valid = 1'b1;
            item.tag   = b[7:4];
            item.kind  = b[3:2];
            item.size  = b[1:0];
            item.value = '0;
         end else begin
            prefix_in  = b;
            pending_in = (b[1:0] == hdip_pkg::SIZE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
            acc_in     = '0;
            pos_in     = '0;
         end
      end else begin
         acc_in     = acc_new;
         pos_in     = pos_ff + 2'd1;
         pending_in = pending_ff - 3'd1;
         if (pending_ff == 3'd1) begin
            item.valid = 1'b1;
            item.tag   = prefix_ff[7:4];
            item.kind  = prefix_ff[3:2];
            item.size  = prefix_ff[1:0];
            item.value = acc_new;
         end
      end
   end

   assign trunc = req_data.last_byte && (pending_in != 3'd0);

   // Advance on each accepted byte; drop back to reset after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         prefix_ff  <= '0;
         acc_ff     <= '0;
         pos_ff     <= '0;
      end else if (accept) begin
         if (req_data.last_byte) begin
            pending_ff <= '0;
            prefix_ff  <= '0;
            acc_ff     <= '0;
            pos_ff     <= '0;
         end else begin
            pending_ff <= pending_in;
            prefix_ff  <= prefix_in;
            acc_ff     <= acc_in;
            pos_ff     <= pos_in;
         end
      end
   end

endmodule

@@ rtl/hdip_state_tracker.sv @@
// Item execution for the HID parser: globals, locals, push/pop stack, field and
// collection counts, device type. Registers one tracker word per accepted byte.
// Depends on hdip_pkg.
`timescale 1ns / 1ps

module hdip_state_tracker #(
   parameter int MAX_FIELDS      = hdip_pkg::MAX_FIELDS_DEF,
   parameter int MAX_COLLECTIONS = hdip_pkg::MAX_COLLECTIONS_DEF,
   parameter int STACK_LEVELS    = hdip_pkg::STACK_LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 last_byte,
   input  logic                 trunc,
   input  hdip_pkg::item_type   item,
   output hdip_pkg::track_type  track_data
);

   localparam int FTW = $clog2(MAX_FIELDS + 1);
   localparam int CTW = $clog2(MAX_COLLECTIONS + 1);
   localparam int SLW = $clog2(STACK_LEVELS + 1);
   localparam int SIW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

   hdip_pkg::globals_type cur_ff, cur_in;
   hdip_pkg::globals_type saved_ff [STACK_LEVELS];
   logic [SLW-1:0] level_ff, level_in;
   logic [FTW-1:0] ft_ff, ft_in;
   logic [CTW-1:0] ct_ff, ct_in;
   logic [2:0]     type_ff, type_in;

   logic           is_main, is_global, is_local;
   logic           fields_item, push_ok, pop_ok;
   logic [FTW-1:0] room, n;
   logic [SIW-1:0] push_idx, pop_idx;
   logic [SLW-1:0] level_dec;

   assign is_main   = item.valid && (item.kind == hdip_pkg::KIND_MAIN);
   assign is_global = item.valid && (item.kind == hdip_pkg::KIND_GLOBAL);
   assign is_local  = item.valid && (item.kind == hdip_pkg::KIND_LOCAL);

   assign fields_item = is_main && ((item.tag == hdip_pkg::TAG_INPUT) ||
                                    (item.tag == hdip_pkg::TAG_OUTPUT) ||
                                    (item.tag == hdip_pkg::TAG_FEATURE));

   // Entries added: report count limited to the room left in the store
   assign room = FTW'(MAX_FIELDS) - ft_ff;
   assign n    = (cur_ff.count < 32'(room)) ? FTW'(cur_ff.count) : room;

   assign push_ok   = is_global && (item.tag == hdip_pkg::TAG_PUSH) &&
                      (level_ff < SLW'(STACK_LEVELS));
   assign pop_ok    = is_global && (item.tag == hdip_pkg::TAG_POP) && (level_ff != '0);
   assign level_dec = level_ff - SLW'(1);
   assign push_idx  = level_ff[SIW-1:0];
   assign pop_idx   = level_dec[SIW-1:0];

   // Execute the completed item
   always_comb begin
      cur_in   = cur_ff;
      level_in = level_ff;
      ft_in    = ft_ff;
      ct_in    = ct_ff;
      type_in  = type_ff;
      if (fields_item) begin
         ft_in = ft_ff + n;
      end
      if (is_main && (item.tag == hdip_pkg::TAG_COLLECTION) &&
          (ct_ff < CTW'(MAX_COLLECTIONS))) begin
         ct_in = ct_ff + CTW'(1);
         if (type_ff == hdip_pkg::DEV_UNKNOWN) begin
            if (cur_ff.page == hdip_pkg::PAGE_DESKTOP) begin
               priority if (cur_ff.usage == hdip_pkg::USE_KEYBOARD) type_in = hdip_pkg::DEV_KEYBOARD;
               else if (cur_ff.usage == hdip_pkg::USE_MOUSE)     type_in = hdip_pkg::DEV_MOUSE;
               else if (cur_ff.usage == hdip_pkg::USE_JOYSTICK)  type_in = hdip_pkg::DEV_JOYSTICK;
               else if (cur_ff.usage == hdip_pkg::USE_GAMEPAD)   type_in = hdip_pkg::DEV_GAMEPAD;
               else                                              type_in = hdip_pkg::DEV_UNKNOWN;
            end else if (cur_ff.page == hdip_pkg::PAGE_DIGITIZER) begin
               type_in = hdip_pkg::DEV_TOUCHSCREEN;
            end
         end
      end
      if (is_global) begin
         if (item.tag == hdip_pkg::TAG_USAGE_PAGE) begin
            cur_in.page = item.value;
         end else if (item.tag == hdip_pkg::TAG_REPORT_COUNT) begin
            cur_in.count = item.value;
         end else if (push_ok) begin
            level_in = level_ff + SLW'(1);
         end else if (pop_ok) begin
            level_in = level_dec;
            cur_in   = saved_ff[pop_idx];
         end
      end
      if (is_local) begin
         if (item.tag == hdip_pkg::TAG_USAGE) begin
            if (item.size != hdip_pkg::SIZE_FOUR) begin
               cur_in.usage = item.value;
            end else begin
               cur_in.page  = {16'h0000, item.value[31:16]};
               cur_in.usage = {16'h0000, item.value[15:0]};
            end
            cur_in.umin = cur_in.usage;
            cur_in.umax = cur_in.usage;
         end else if (item.tag == hdip_pkg::TAG_USAGE_MIN) begin
            cur_in.umin = item.value;
         end else if (item.tag == hdip_pkg::TAG_USAGE_MAX) begin
            cur_in.umax = item.value;
         end
      end
   end

   // Hold parser state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         level_ff <= '0;
         ft_ff    <= '0;
         ct_ff    <= '0;
         type_ff  <= hdip_pkg::DEV_UNKNOWN;
      end else if (accept) begin
         if (last_byte) begin
            cur_ff   <= '0;
            level_ff <= '0;
            ft_ff    <= '0;
            ct_ff    <= '0;
            type_ff  <= hdip_pkg::DEV_UNKNOWN;
         end else begin
            cur_ff   <= cur_in;
            level_ff <= level_in;
            ft_ff    <= ft_in;
            ct_ff    <= ct_in;
            type_ff  <= type_in;
         end
      end
   end

   // Save globals on push
   always_ff @(posedge clock) begin
      if (accept && push_ok) begin
         saved_ff[push_idx] <= cur_ff;
      end
   end

   // Register the tracker word for the tally stage
   always_ff @(posedge clock) begin
      if (accept) begin
         track_data.done        <= last_byte;
         track_data.trunc       <= trunc;
         track_data.device_type <= type_in;
         track_data.fields      <= hdip_pkg::FIELD_W'(ft_in);
         track_data.colls       <= hdip_pkg::COLL_W'(ct_in);
         track_data.add_n       <= fields_item ? hdip_pkg::FIELD_W'(n) : '0;
         track_data.count       <= cur_ff.count;
         track_data.page_kbd    <= (cur_ff.page == hdip_pkg::PAGE_KEYBOARD);
         track_data.page_btn    <= (cur_ff.page == hdip_pkg::PAGE_BUTTON);
         track_data.page_desk   <= (cur_ff.page == hdip_pkg::PAGE_DESKTOP);
         track_data.umin        <= cur_ff.umin;
      end
   end

endmodule

@@ rtl/hdip_tally.sv @@
// Key, button and axis totals for the HID parser, plus the result register.
// Two stages: product and axis hits, then accumulate. Depends on hdip_pkg.
`timescale 1ns / 1ps

module hdip_tally #(
   parameter int MAX_FIELDS = hdip_pkg::MAX_FIELDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                track_valid,
   input  hdip_pkg::track_type track_data,
   output logic                track_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hdip_pkg::rsp_type   rsp_data
);

   localparam int FTW = $clog2(MAX_FIELDS + 1);

   hdip_pkg::tally_type tally_ff;
   logic                tally_valid_ff;
   logic                rsp_valid_ff;
   logic [31:0]         keys_ff, keys_in;
   logic [31:0]         btns_ff, btns_in;
   logic [FTW-1:0]      axes_ff, axes_in;

   logic                out_load, tally_load;
   logic [31:0]         n_ext, product;
   logic [hdip_pkg::AXIS_NUM-1:0] axis_hit;

   // Stall handshake: each stage loads when empty or when it drains
   assign out_load    = !rsp_valid_ff || rsp_ready;
   assign tally_load  = !tally_valid_ff || out_load;
   assign track_ready = tally_load;

   // Product of entries and report count, mod 2^32
   assign n_ext   = 32'(track_data.add_n);
   assign product = n_ext * track_data.count;

   // Flag each X..Rz usage that falls inside the added usage range
   always_comb begin
      for (int k = 0; k < hdip_pkg::AXIS_NUM; k++) begin
         axis_hit[k] = track_data.page_desk &&
                       ((hdip_pkg::AXIS_FIRST + 32'(k) - track_data.umin) < n_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (tally_load && track_valid) begin
         tally_ff.done        <= track_data.done;
         tally_ff.trunc       <= track_data.trunc;
         tally_ff.device_type <= track_data.device_type;
         tally_ff.fields      <= track_data.fields;
         tally_ff.colls       <= track_data.colls;
         tally_ff.key_add     <= track_data.page_kbd ? product : '0;
         tally_ff.btn_add     <= track_data.page_btn ? product : '0;
         tally_ff.axis_inc    <= 3'($countones(axis_hit));
      end
   end

   // Accumulate totals
   assign keys_in = keys_ff + tally_ff.key_add;
   assign btns_in = btns_ff + tally_ff.btn_add;
   assign axes_in = axes_ff + FTW'(tally_ff.axis_inc);

   // Advance valid bits; clear totals after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         tally_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         keys_ff        <= '0;
         btns_ff        <= '0;
         axes_ff        <= '0;
      end else begin
         if (tally_load) begin
            tally_valid_ff <= track_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= tally_valid_ff;
            if (tally_valid_ff) begin
               if (tally_ff.done) begin
                  keys_ff <= '0;
                  btns_ff <= '0;
                  axes_ff <= '0;
               end else begin
                  keys_ff <= keys_in;
                  btns_ff <= btns_in;
                  axes_ff <= axes_in;
               end
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load && tally_valid_ff) begin
         rsp_data.done_res           <= tally_ff.done;
         rsp_data.device_type        <= tally_ff.device_type;
         rsp_data.key_count          <= keys_in;
         rsp_data.button_count       <= btns_in;
         rsp_data.axis_count         <= 8'(axes_in);
         rsp_data.fields_stored      <= 8'(tally_ff.fields);
         rsp_data.collections_stored <= 5'(tally_ff.colls);
         rsp_data.truncated          <= tally_ff.trunc;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/hid_descriptor_item_parser.sv @@
// Top level of the HID report descriptor item parser.
// Instantiates hdip_item_gather, hdip_state_tracker and hdip_tally; uses hdip_pkg.
`timescale 1ns / 1ps
//
//   channel   ports                            word
//   -------   ------------------------------   -------------------------------
//   input     req_valid, req_ready, req_data   one descriptor byte, last flag
//   result    rsp_valid, rsp_ready, rsp_data   running totals, one per byte
//
// One descriptor byte is accepted per cycle while req_ready is high; each gives one
// result word after the tracker register, tally register and result register.
// The multiply of entries by report count sits in the tally stage, beside the axis checks.
// Synchronous active-high reset clears parser state, totals and valid bits.
// A stalled result holds only the result register; earlier stages keep
// filling until every stage holds a word, then req_ready drops.

module hid_descriptor_item_parser #(
   parameter int MAX_FIELDS      = hdip_pkg::MAX_FIELDS_DEF,
   parameter int MAX_COLLECTIONS = hdip_pkg::MAX_COLLECTIONS_DEF,
   parameter int STACK_LEVELS    = hdip_pkg::STACK_LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdip_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdip_pkg::rsp_type rsp_data
);

   hdip_pkg::item_type  item;
   hdip_pkg::track_type track_data;
   logic                trunc;
   logic                accept;
   logic                track_valid_ff;
   logic                track_ready;

   assign req_ready = !track_valid_ff || track_ready;
   assign accept    = req_valid && req_ready;

   hdip_item_gather u_gather (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .item     (item),
      .trunc    (trunc)
   );

   hdip_state_tracker #(
      .MAX_FIELDS      (MAX_FIELDS),
      .MAX_COLLECTIONS (MAX_COLLECTIONS),
      .STACK_LEVELS    (STACK_LEVELS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .last_byte  (req_data.last_byte),
      .trunc      (trunc),
      .item       (item),
      .track_data (track_data)
   );

   // Track valid bit of the tracker register
   always_ff @(posedge clock) begin
      if (reset) begin
         track_valid_ff <= 1'b0;
      end else if (req_ready) begin
         track_valid_ff <= req_valid;
      end
   end

   hdip_tally #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .track_valid (track_valid_ff),
      .track_data  (track_data),
      .track_ready (track_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // Field count in the tracker register never passes the store size
   a_fields_capped: assert property (@(posedge clock) disable iff (reset)
      track_valid_ff |-> (track_data.fields <= hdip_pkg::FIELD_W'(MAX_FIELDS)))
      else $error("field count above store size");

   // Collection count never passes the store size
   a_colls_capped: assert property (@(posedge clock) disable iff (reset)
      track_valid_ff |-> (track_data.colls <= hdip_pkg::COLL_W'(MAX_COLLECTIONS)))
      else $error("collection count above store size");

   // An accepted byte lands in the tracker register with its last flag
   a_track_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> (track_valid_ff && (track_data.done == $past(req_data.last_byte))))
      else $error("tracker word lost or last flag wrong");

   // Truncation is only flagged on the last word
   a_trunc_done: assert property (@(posedge clock) disable iff (reset)
      (track_valid_ff && track_data.trunc) |-> track_data.done)
      else $error("truncation flagged on a word that is not last");

endmodule
